// ===== hw/rtl/pcmu_pkg.sv =====
// pcmu_pkg: shared types, format codes and constants for the pcm unpack block
// used by the front, queue, back and top-level modules
`default_nettype none

package pcmu_pkg;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 20;
  localparam int BYTE_W   = 8;
  localparam int HELD_W   = 16;
  localparam int CFG_W    = 20;

  // gain fixed point
  localparam int GAIN_FRAC_BITS = 16;
  localparam logic [63:0] GAIN_UNITY = 64'd1 << GAIN_FRAC_BITS;
  localparam int PROD_W = SAMPLE_W + GAIN_W;

  // sample format codes
  localparam logic [1:0] FMT_U8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;
  localparam logic [1:0] FMT_S24 = 2'd2;
  localparam logic [1:0] FMT_BAD = 2'd3;

  // register indexes
  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  // register reset values
  localparam logic [1:0]        FORMAT_RESET = FMT_S16;
  localparam logic [GAIN_W-1:0] GAIN_RESET   = GAIN_W'(GAIN_UNITY);

  // 8-bit unsigned offset
  localparam logic [BYTE_W-1:0] U8_OFFSET = 8'h80;

  // saturation limits on the magnitude after scaling
  localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(64'h7FFF_FFFF);
  localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(64'h8000_0000);

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // one gathered sample on its way to the gain stage
  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    logic                err;
  } pcmu_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pcm_unpack_gain_saturate.sv =====
// pcm_unpack_gain_saturate: top level with configuration registers
// depends on pcmu_pkg, pcmu_front, pcmu_queue, pcmu_back
//
// Usage:
//   Input channel (in_valid, in_stall, data_byte, block_start) carries one
//   byte of little-endian PCM per transfer. block_start drops any partial
//   sample before the byte is taken. Output channel (out_valid, out_stall,
//   sample, format_error) carries one gained, saturated 32-bit sample per
//   completed sample, or one error result per byte when the format is
//   unsupported.
//   Configuration: cfg_write with cfg_index 0 sets sample_format, index 1
//   sets the Q4.16 gain; write only while the block is idle.
//   Throughput: one byte per clock while in_stall is low. A result passes
//   through the queue and then the magnitude, multiply and saturate
//   stages after the transfer of its last byte.
//   A 4-entry queue parts the byte front end from the multiply pipeline;
//   in_stall rises only when that queue is full.
//   When out_stall is high with out_valid set, the output holds its result
//   and the back end freezes; the front keeps taking bytes until the queue fills.
//   Reset empties the queue and pipeline, drops any partial sample, sets
//   the format to 16-bit and the gain to unity.
`default_nettype none

module pcm_unpack_gain_saturate
  import pcmu_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [BYTE_W-1:0]     data_byte,
  input  wire logic                  block_start,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       format_error
);

  logic [1:0]        sample_format;
  logic [GAIN_W-1:0] gain;
  logic              push, pop, full, empty;
  pcmu_item_t        push_item, pop_item;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FORMAT_RESET;
      gain          <= GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FORMAT: sample_format <= cfg_data[1:0];
        REG_GAIN:   gain          <= cfg_data[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  pcmu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .sample_format (sample_format),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .block_start   (block_start),
    .queue_full    (full),
    .push          (push),
    .push_item     (push_item)
  );

  pcmu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  pcmu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gain         (gain),
    .queue_item   (pop_item),
    .queue_empty  (empty),
    .queue_pop    (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .format_error (format_error)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/pcmu_front.sv =====
// pcmu_front: takes raw bytes, gathers them into left-justified samples
// depends on pcmu_pkg
`default_nettype none

module pcmu_front
  import pcmu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        sample_format,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              block_start,
  input  wire logic              queue_full,
  output logic                   push,
  output pcmu_item_t             push_item
);

  logic [HELD_W-1:0] held, held_next;
  logic [1:0]        cnt, cnt_next;
  logic [HELD_W-1:0] hb;
  logic [1:0]        hc, hc_sat;
  logic              has_result;
  logic              accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept && has_result;

  // byte gathering and classification
  always_comb begin
    hb     = block_start ? '0 : held;
    hc     = block_start ? 2'd0 : cnt;
    hc_sat = (hc == 2'd3) ? 2'd2 : hc;
    held_next      = hb;
    cnt_next       = hc;
    has_result     = 1'b0;
    push_item.raw  = '0;
    push_item.err  = 1'b0;
    unique case (sample_format)
      FMT_U8: begin
        has_result    = 1'b1;
        push_item.raw = {data_byte ^ U8_OFFSET, 24'd0};
        held_next     = '0;
        cnt_next      = 2'd0;
      end
      FMT_S16: begin
        if (hc_sat == 2'd0) begin
          held_next = {8'd0, data_byte};
          cnt_next  = 2'd1;
        end else begin
          has_result    = 1'b1;
          push_item.raw = {data_byte, hb[7:0], 16'd0};
          held_next     = '0;
          cnt_next      = 2'd0;
        end
      end
      FMT_S24: begin
        if (hc_sat == 2'd0) begin
          held_next = {8'd0, data_byte};
          cnt_next  = 2'd1;
        end else if (hc_sat == 2'd1) begin
          held_next = {data_byte, hb[7:0]};
          cnt_next  = 2'd2;
        end else begin
          has_result    = 1'b1;
          push_item.raw = {data_byte, hb, 8'd0};
          held_next     = '0;
          cnt_next      = 2'd0;
        end
      end
      default: begin
        // unsupported width: error result, partial sample dropped
        has_result    = 1'b1;
        push_item.err = 1'b1;
        held_next     = '0;
        cnt_next      = 2'd0;
      end
    endcase
  end

  // partial sample state
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      cnt  <= 2'd0;
    end else if (accept) begin
      held <= held_next;
      cnt  <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcmu_queue.sv =====
// pcmu_queue: short first-in first-out queue between front and back
// depends on pcmu_pkg
`default_nettype none

module pcmu_queue
  import pcmu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire pcmu_item_t push_item,
  input  wire logic       pop,
  output pcmu_item_t      pop_item,
  output logic            full,
  output logic            empty
);

  pcmu_item_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]       count;

  assign full     = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcmu_back.sv =====
// pcmu_back: gain multiply, truncation toward zero and saturation
// depends on pcmu_pkg
`default_nettype none

module pcmu_back
  import pcmu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [GAIN_W-1:0]   gain,
  input  wire pcmu_item_t          queue_item,
  input  wire logic                queue_empty,
  output logic                     queue_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                     format_error
);

  logic                adv;

  // stage 1: sign and magnitude
  logic                s1_valid;
  logic                s1_neg, s1_err, s1_bypass;
  logic [SAMPLE_W-1:0] s1_mag, s1_raw;

  // stage 2: product
  logic                s2_valid;
  logic                s2_neg, s2_err, s2_bypass;
  logic [SAMPLE_W-1:0] s2_raw;
  logic [PROD_W-1:0]   s2_prod;

  // stage 3 next values
  logic [PROD_W-1:0]   scaled;
  logic [SAMPLE_W-1:0] result;

  // whole pipeline moves unless the output holds a stalled result
  assign adv       = !out_valid || !out_stall;
  assign queue_pop = adv && !queue_empty;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= queue_pop;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_raw    <= queue_item.raw;
      s1_err    <= queue_item.err;
      s1_neg    <= queue_item.raw[SAMPLE_W-1];
      s1_mag    <= queue_item.raw[SAMPLE_W-1] ? (~queue_item.raw + 1'b1) : queue_item.raw;
      s1_bypass <= ({{(64-GAIN_W){1'b0}}, gain} == GAIN_UNITY);
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_raw    <= s1_raw;
      s2_err    <= s1_err;
      s2_neg    <= s1_neg;
      s2_bypass <= s1_bypass;
      s2_prod   <= PROD_W'(s1_mag) * PROD_W'(gain);
    end
  end

  // truncate, saturate and restore sign
  always_comb begin
    scaled = s2_prod >> GAIN_FRAC_BITS;
    if (s2_err) begin
      result = '0;
    end else if (s2_bypass) begin
      result = s2_raw;
    end else if (!s2_neg) begin
      result = (scaled > POS_LIMIT) ? POS_LIMIT[SAMPLE_W-1:0] : scaled[SAMPLE_W-1:0];
    end else if (scaled > NEG_LIMIT) begin
      result = ~NEG_LIMIT[SAMPLE_W-1:0] + 1'b1;
    end else begin
      result = ~scaled[SAMPLE_W-1:0] + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      sample       <= result;
      format_error <= s2_err;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pcmu_checker.sv =====
// pcmu_checker: port-level checks on the top level, attached by bind
// depends on pcmu_pkg
`default_nettype none

module pcmu_checker
  import pcmu_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [SAMPLE_W-1:0] sample,
  input wire logic                format_error
);

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // an error result always carries a zero sample
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && format_error) |-> (sample == '0))
    else $error("error result with nonzero sample");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(sample) && $stable(format_error)))
    else $error("stalled result changed");

endmodule

bind pcm_unpack_gain_saturate pcmu_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .sample       (sample),
  .format_error (format_error)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for pcm_unpack_gain_saturate, byte stream in, gained samples out
// depends on pcmu_pkg and the pcm_unpack_gain_saturate rtl

module tb;
  import pcmu_pkg::*;

  localparam int LATENCY     = 3;
  localparam int IDLE_LIMIT  = 3000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 105;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                err;
  } pcm_result_t;

  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_write    = 1'b0;
  logic                       cfg_index    = REG_FORMAT;
  logic [CFG_W-1:0]           cfg_data     = '0;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [BYTE_W-1:0]          data_byte    = '0;
  logic                       block_start  = 1'b0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       format_error;

  // predictor state and configuration copy
  logic [1:0]        model_format = FORMAT_RESET;
  logic [GAIN_W-1:0] model_gain   = GAIN_RESET;
  logic [HELD_W-1:0] model_held   = '0;
  logic [1:0]        model_count  = '0;

  pcm_result_t pending_samples[$];
  pcm_result_t head;
  int          mismatch_count = 0;
  int          tx_idle_pct    = 0;
  int          rx_stall_pct   = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;

  pcm_unpack_gain_saturate dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .block_start  (block_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .format_error (format_error)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // gain with truncation toward zero and signed 32-bit saturation
  function automatic logic [SAMPLE_W-1:0] apply_gain(input logic [SAMPLE_W-1:0] s,
                                                      input logic [GAIN_W-1:0] g);
    logic                neg;
    logic [SAMPLE_W-1:0] neg_s;
    logic [SAMPLE_W-1:0] q_low;
    logic [63:0]         mag;
    logic [63:0]         q;
    if ({44'd0, g} == GAIN_UNITY) begin
      return s;
    end
    neg   = s[SAMPLE_W-1];
    neg_s = ~s + 32'd1;
    mag   = {32'd0, neg ? neg_s : s};
    q     = (mag * {44'd0, g}) >> GAIN_FRAC_BITS;
    if (!neg) begin
      return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    if (q > 64'h8000_0000) begin
      q = 64'h8000_0000;
    end
    q_low = q[31:0];
    return ~q_low + 32'd1;
  endfunction

  // byte gathering, one accepted transfer at a time
  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic bs);
    logic [1:0]          cnt;
    logic [SAMPLE_W-1:0] raw;
    logic                done;
    pcm_result_t         r;
    raw  = '0;
    done = 1'b1;
    r    = '0;
    if (bs) begin
      model_held  = '0;
      model_count = '0;
    end
    // a count of three is taken as two
    cnt = (model_count == 2'd3) ? 2'd2 : model_count;
    case (model_format)
      FMT_U8: begin
        raw = {b ^ U8_OFFSET, 24'd0};
      end
      FMT_S16: begin
        if (cnt == 2'd0) begin
          model_held  = {8'd0, b};
          model_count = 2'd1;
          done        = 1'b0;
        end else begin
          raw = {b, model_held[7:0], 16'd0};
        end
      end
      FMT_S24: begin
        if (cnt < 2'd2) begin
          model_held  = (cnt == 2'd0) ? {8'd0, b} : {b, model_held[7:0]};
          model_count = cnt + 2'd1;
          done        = 1'b0;
        end else begin
          raw = {b, model_held, 8'd0};
        end
      end
      default: begin
        r.err = 1'b1;
      end
    endcase
    if (done) begin
      model_held  = '0;
      model_count = '0;
      r.value     = r.err ? '0 : apply_gain(raw, model_gain);
      pending_samples.push_back(r);
    end
  endtask

  // offer one byte, with random sender gaps, until the transfer happens
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic bs);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    block_start <= bs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(b, bs);
  endtask

  // stop sending and let every expected result come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FORMAT) begin
      model_format = val[1:0];
    end else begin
      model_gain = val[GAIN_W-1:0];
    end
  endtask

  // upper data bits are don't-care for the format register
  task automatic set_format(input logic [1:0] fmt);
    write_reg(REG_FORMAT, {18'($urandom), fmt});
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] g);
    write_reg(REG_GAIN, g);
  endtask

  // reset defaults: 16-bit, unity gain, block start dropping a held byte
  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h56, 1'b0);
  endtask

  task automatic test_unsigned_8bit();
    set_format(FMT_U8);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_signed_24bit();
    set_format(FMT_S24);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hBB, 1'b0);
    send_byte(8'hCC, 1'b0);
  endtask

  // zero gain, saturation both ways, a negative sample with a fractional gain
  task automatic test_gain_extremes();
    set_format(FMT_S16);
    set_gain('0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    set_gain('1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    set_gain(20'h0_8001);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    set_gain(GAIN_RESET);
  endtask

  // unsupported format: one error per byte, partial sample dropped
  task automatic test_bad_format();
    set_format(FMT_S24);
    send_byte(8'h11, 1'b0);
    set_format(FMT_BAD);
    send_byte(8'h22, 1'b1);
    set_format(FMT_S24);
    send_byte(8'h44, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b0);
  endtask

  // format changed with bytes held
  task automatic test_format_switch();
    set_format(FMT_S24);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    set_format(FMT_S16);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    set_format(FMT_S24);
    send_byte(8'h05, 1'b0);
    send_byte(8'h06, 1'b0);
    send_byte(8'h07, 1'b0);
    set_format(FMT_U8);
    send_byte(8'h08, 1'b0);
  endtask

  // long receiver hold while bytes keep coming, then a full drain
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    set_format(FMT_U8);
    set_gain(20'h1_8000);
    hold_left = 300;
    for (int i = 0; i < 40; i++) begin
      send_byte(8'($urandom), 1'b0);
    end
    wait_drained();
    for (int i = 0; i < 10; i++) begin
      send_byte(8'($urandom), 1'b0);
    end
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: begin
        return GAIN_RESET;
      end
      1: begin
        return '0;
      end
      2: begin
        return '1;
      end
      3: begin
        return GAIN_RESET + GAIN_W'($urandom_range(2)) - GAIN_W'(1);
      end
      4: begin
        return GAIN_W'($urandom_range(0, 20'h1_FFFF));
      end
      default: begin
        return GAIN_W'($urandom);
      end
    endcase
  endfunction

  // random segments, each under its own format and gain
  task automatic test_random_phase(input int tx_pct, input int rx_pct);
    int sent;
    int seg;
    int pick;
    sent         = 0;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(9);
      set_format((pick < 9) ? 2'(pick % 3) : FMT_BAD);
      set_gain(pick_gain());
      seg = $urandom_range(10, 40);
      for (int i = 0; i < seg; i++) begin
        send_byte(8'($urandom), ($urandom_range(99) < 4));
      end
      sent += seg;
    end
  endtask

  // receiver stall, with a counted hold when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // result check against the oldest expected sample
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected result: sample %h err %b", sample, format_error);
        end
        mismatch_count++;
      end else begin
        head = pending_samples.pop_front();
        if (sample !== head.value || format_error !== head.err) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("mismatch: expected sample %h err %b, got sample %h err %b",
                     head.value, head.err, sample, format_error);
          end
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // test sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_unsigned_8bit();
    test_signed_24bit();
    test_gain_extremes();
    test_bad_format();
    test_format_switch();
    test_backpressure();
    test_random_phase(0, 0);
    test_random_phase(50, 0);
    test_random_phase(0, 50);
    test_random_phase(26, 26);
    wait_drained();
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
